FILE: src/mrtu_pkg.sv
// Shared constants and the CRC-16/MODBUS byte update for the Modbus RTU master framer.
// No dependencies; the framer and the checker refer to this package by scoped names.
`default_nettype none

package mrtu_pkg;

   // Function codes and exception flag
   localparam logic [7:0] CODE_READ  = 8'd4;
   localparam logic [7:0] CODE_WRITE = 8'd6;
   localparam logic [7:0] EXC_FLAG   = 8'h80;

   // Receive position limits
   localparam logic [8:0] POS_MAX     = 9'd511;
   localparam logic [8:0] HDR_TRAILER = 9'd5;

   // Request frame: six header bytes, then two CRC bytes
   localparam logic [2:0] TX_HDR_LAST = 3'd5;
   localparam logic [2:0] TX_CRC_LO   = 3'd6;
   localparam logic [2:0] TX_CRC_HI   = 3'd7;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_WORD   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ADDR   = 3'd1;
   localparam logic [2:0] ST_EXCEPTION  = 3'd2;
   localparam logic [2:0] ST_BAD_CODE   = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE = 3'd4;
   localparam logic [2:0] ST_CRC_ERR    = 3'd5;

   // One byte through the reflected CRC: eight shift/xor steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: src/mrtu_if.sv
// Valid/ready channel interfaces for the request and result items of the framer.
// Depends on nothing; widths follow the item fields.
`default_nettype none

interface mrtu_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic        request_kind;
   logic [7:0]  device_address;
   logic [15:0] register_address;
   logic [15:0] count_or_value;
   logic [7:0]  rx_byte;
   logic        rx_last;

   modport source (output valid, op, request_kind, device_address, register_address,
                   count_or_value, rx_byte, rx_last, input ready);
   modport sink   (input valid, op, request_kind, device_address, register_address,
                   count_or_value, rx_byte, rx_last, output ready);
endinterface

interface mrtu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  tx_byte;
   logic [15:0] payload_word;
   logic [2:0]  status;
   logic [7:0]  exception_code;
   logic        last;

   modport source (output valid, kind, tx_byte, payload_word, status, exception_code,
                   last, input ready);
   modport sink   (input valid, kind, tx_byte, payload_word, status, exception_code,
                   last, output ready);
endinterface

`default_nettype wire

FILE: src/modbus_rtu_master_framer.sv
// Modbus RTU master framer: request frame builder and response checker.
// Depends on mrtu_pkg and the channel interfaces in mrtu_if.sv.
//
// Usage:
//   req_if carries one item per handshake: op 0 issues a request frame
//   (read input registers or write single register), op 1 delivers one
//   received response byte, rx_last marking the frame's final byte.
//   rsp_if carries the results: transmit bytes (kind 0), provisional payload
//   words (kind 1) and one final status per response frame (kind 2).
// Latency: an item's first result appears the cycle after it is accepted.
// Results: a response byte yields at most a payload word and its status;
//   a request yields its eight frame bytes, held one at a time in the
//   single-result output register. The request CRC is built one byte per
//   emitted header byte.
// A new item is accepted in the same cycle the last pending result is taken,
//   so unstalled response bytes run at one per cycle within a frame.
// Stall: when rsp_if.ready is low the pending result holds and req_if.ready
//   drops until it is taken; no state is lost.
// Reset (synchronous): clears the output buffer, forgets the expected
//   address and code, and returns the receive state to its initial values.
`default_nettype none

module modbus_rtu_master_framer (
   input  wire logic   clock,
   input  wire logic   reset,
   mrtu_req_if.sink    req_if,
   mrtu_rsp_if.source  rsp_if
);

   // Request/receive state
   logic [7:0]  exp_addr_ff, exp_addr_in;
   logic        known_ff, known_in;
   logic [7:0]  exp_code_ff, exp_code_in;
   logic [8:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  err_ff, err_in;
   logic [7:0]  decl_ff, decl_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [7:0]  held2_ff, held2_in;

   // Output buffer
   logic        tx_busy_ff, tx_busy_in;
   logic [2:0]  tx_idx_ff, tx_idx_in;
   logic [47:0] frame_ff, frame_in;
   logic [15:0] tx_crc_ff, tx_crc_in;
   logic        word_vld_ff, word_vld_in;
   logic [15:0] word_ff, word_in;
   logic        stat_vld_ff, stat_vld_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  exc_ff, exc_in;

   logic busy;
   logic final_res;
   logic rsp_take;
   logic accept;
   logic is_req;
   logic is_rx;

   // Receive byte decode
   logic        is_read;
   logic [8:0]  start_pos;
   logic [8:0]  q_pos;
   logic [2:0]  rx_err;
   logic [7:0]  rx_decl;
   logic [15:0] rx_crc;
   logic        word_emit;
   logic [2:0]  rx_status;
   logic [7:0]  rx_exc;

   // Handshake
   assign busy      = tx_busy_ff | word_vld_ff | stat_vld_ff;
   assign final_res = tx_busy_ff ? (tx_idx_ff == mrtu_pkg::TX_CRC_HI)
                                 : (word_vld_ff ^ stat_vld_ff);
   assign rsp_take  = busy && rsp_if.ready;
   assign req_if.ready = !busy || (rsp_if.ready && final_res);
   assign accept    = req_if.valid && req_if.ready;
   assign is_req    = accept && !req_if.op;
   assign is_rx     = accept && req_if.op;

   // Response byte checks, CRC and payload pairing
   always_comb begin
      is_read   = (exp_code_ff == mrtu_pkg::CODE_READ);
      start_pos = is_read ? 9'd3 : 9'd2;
      q_pos     = pos_ff - 9'd2;

      rx_err = err_ff;
      if (pos_ff == 9'd0) begin
         if (!known_ff || req_if.rx_byte != exp_addr_ff) begin
            rx_err = mrtu_pkg::ST_BAD_ADDR;
         end
      end else if (pos_ff == 9'd1) begin
         if (err_ff == mrtu_pkg::ST_OK && req_if.rx_byte != exp_code_ff) begin
            rx_err = (req_if.rx_byte >= mrtu_pkg::EXC_FLAG) ? mrtu_pkg::ST_EXCEPTION
                                                            : mrtu_pkg::ST_BAD_CODE;
         end
      end

      rx_decl = (pos_ff == 9'd2) ? req_if.rx_byte : decl_ff;

      // byte pos-2 is now known not to be a CRC byte
      rx_crc    = crc_ff;
      word_emit = 1'b0;
      if (pos_ff >= 9'd2) begin
         rx_crc    = mrtu_pkg::crc_byte(crc_ff, held1_ff);
         word_emit = (pos_ff < mrtu_pkg::POS_MAX) && (rx_err == mrtu_pkg::ST_OK) &&
                     (q_pos > start_pos) && (q_pos[0] != start_pos[0]);
      end

      // Final status, in check order
      rx_exc = 8'h00;
      if (pos_ff < 9'd3) begin
         rx_status = mrtu_pkg::ST_INCOMPLETE;
      end else if (rx_err != mrtu_pkg::ST_OK) begin
         rx_status = rx_err;
         if (rx_err == mrtu_pkg::ST_EXCEPTION) begin
            rx_exc = rx_decl;
         end
      end else if (is_read &&
                   ({1'b0, rx_decl} != pos_ff + 9'd1 - mrtu_pkg::HDR_TRAILER)) begin
         rx_status = mrtu_pkg::ST_INCOMPLETE;
      end else if ({req_if.rx_byte, held2_ff} == rx_crc) begin
         rx_status = mrtu_pkg::ST_OK;
      end else begin
         rx_status = mrtu_pkg::ST_CRC_ERR;
      end
   end

   // Next state of the request/receive registers
   always_comb begin
      exp_addr_in = exp_addr_ff;
      known_in    = known_ff;
      exp_code_in = exp_code_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      err_in      = err_ff;
      decl_in     = decl_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      held2_in    = held2_ff;

      if (is_req || (is_rx && req_if.rx_last)) begin
         // a request discards any partial response; a status ends the frame
         pos_in   = 9'd0;
         crc_in   = mrtu_pkg::CRC_INIT;
         err_in   = mrtu_pkg::ST_OK;
         decl_in  = 8'h00;
         held0_in = 8'h00;
         held1_in = 8'h00;
         held2_in = 8'h00;
      end else if (is_rx) begin
         crc_in   = rx_crc;
         err_in   = rx_err;
         decl_in  = rx_decl;
         held0_in = held1_ff;
         held1_in = held2_ff;
         held2_in = req_if.rx_byte;
         if (pos_ff < mrtu_pkg::POS_MAX) begin
            pos_in = pos_ff + 9'd1;
         end
      end

      if (is_req) begin
         exp_addr_in = req_if.device_address;
         exp_code_in = req_if.request_kind ? mrtu_pkg::CODE_WRITE : mrtu_pkg::CODE_READ;
         known_in    = 1'b1;
      end
   end

   // Next state of the output buffer: retire the taken result, then load
   always_comb begin
      tx_busy_in  = tx_busy_ff;
      tx_idx_in   = tx_idx_ff;
      frame_in    = frame_ff;
      tx_crc_in   = tx_crc_ff;
      word_vld_in = word_vld_ff;
      word_in     = word_ff;
      stat_vld_in = stat_vld_ff;
      status_in   = status_ff;
      exc_in      = exc_ff;

      if (rsp_take) begin
         if (tx_busy_ff) begin
            if (tx_idx_ff == mrtu_pkg::TX_CRC_HI) begin
               tx_busy_in = 1'b0;
            end else begin
               tx_idx_in = tx_idx_ff + 3'd1;
            end
            if (tx_idx_ff <= mrtu_pkg::TX_HDR_LAST) begin
               tx_crc_in = mrtu_pkg::crc_byte(tx_crc_ff, frame_ff[47:40]);
               frame_in  = {frame_ff[39:0], 8'h00};
            end
         end else if (word_vld_ff) begin
            word_vld_in = 1'b0;
         end else begin
            stat_vld_in = 1'b0;
         end
      end

      if (is_req) begin
         tx_busy_in = 1'b1;
         tx_idx_in  = 3'd0;
         tx_crc_in  = mrtu_pkg::CRC_INIT;
         frame_in   = {req_if.device_address,
                       (req_if.request_kind ? mrtu_pkg::CODE_WRITE : mrtu_pkg::CODE_READ),
                       req_if.register_address, req_if.count_or_value};
      end else if (is_rx) begin
         word_vld_in = word_emit;
         word_in     = {held0_ff, held1_ff};
         stat_vld_in = req_if.rx_last;
         status_in   = rx_status;
         exc_in      = rx_exc;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_addr_ff <= 8'h00;
         known_ff    <= 1'b0;
         exp_code_ff <= 8'h00;
         pos_ff      <= 9'd0;
         crc_ff      <= mrtu_pkg::CRC_INIT;
         err_ff      <= mrtu_pkg::ST_OK;
         decl_ff     <= 8'h00;
         held0_ff    <= 8'h00;
         held1_ff    <= 8'h00;
         held2_ff    <= 8'h00;
         tx_busy_ff  <= 1'b0;
         tx_idx_ff   <= 3'd0;
         word_vld_ff <= 1'b0;
         stat_vld_ff <= 1'b0;
      end else begin
         exp_addr_ff <= exp_addr_in;
         known_ff    <= known_in;
         exp_code_ff <= exp_code_in;
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         err_ff      <= err_in;
         decl_ff     <= decl_in;
         held0_ff    <= held0_in;
         held1_ff    <= held1_in;
         held2_ff    <= held2_in;
         tx_busy_ff  <= tx_busy_in;
         tx_idx_ff   <= tx_idx_in;
         word_vld_ff <= word_vld_in;
         stat_vld_ff <= stat_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      frame_ff  <= frame_in;
      tx_crc_ff <= tx_crc_in;
      word_ff   <= word_in;
      status_ff <= status_in;
      exc_ff    <= exc_in;
   end

   // Result channel
   always_comb begin
      rsp_if.valid          = busy;
      rsp_if.kind           = mrtu_pkg::KIND_STATUS;
      rsp_if.tx_byte        = 8'h00;
      rsp_if.payload_word   = 16'h0000;
      rsp_if.status         = mrtu_pkg::ST_OK;
      rsp_if.exception_code = 8'h00;
      rsp_if.last           = 1'b0;
      if (tx_busy_ff) begin
         rsp_if.kind = mrtu_pkg::KIND_TX;
         rsp_if.last = (tx_idx_ff == mrtu_pkg::TX_CRC_HI);
         if (tx_idx_ff <= mrtu_pkg::TX_HDR_LAST) begin
            rsp_if.tx_byte = frame_ff[47:40];
         end else if (tx_idx_ff == mrtu_pkg::TX_CRC_LO) begin
            rsp_if.tx_byte = tx_crc_ff[7:0];
         end else begin
            rsp_if.tx_byte = tx_crc_ff[15:8];
         end
      end else if (word_vld_ff) begin
         rsp_if.kind         = mrtu_pkg::KIND_WORD;
         rsp_if.payload_word = word_ff;
      end else if (stat_vld_ff) begin
         rsp_if.status         = status_ff;
         rsp_if.exception_code = exc_ff;
         rsp_if.last           = 1'b1;
      end
   end

endmodule

`default_nettype wire

FILE: src/mrtu_checker.sv
// Port-level checks for the Modbus RTU master framer, bound to its top level.
// Depends on mrtu_pkg and modbus_rtu_master_framer.
`default_nettype none

module mrtu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [2:0] rsp_status,
   input wire logic [7:0] rsp_exception_code,
   input wire logic       rsp_last
);

   // A pending result is never withdrawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Nothing pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // No item is taken in while a request frame is still going out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mrtu_pkg::KIND_TX && !rsp_last |-> !(req_valid && req_ready))
      else $error("item accepted in the middle of a request frame");

   // Status results close a frame, payload words never do
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == mrtu_pkg::KIND_STATUS) == rsp_last) ||
                    (rsp_kind == mrtu_pkg::KIND_TX))
      else $error("last flag inconsistent with result kind");

   // An exception byte shows only with exception status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exception_code != 8'h00 |-> rsp_status == mrtu_pkg::ST_EXCEPTION)
      else $error("exception byte without exception status");

endmodule

bind modbus_rtu_master_framer mrtu_checker u_mrtu_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_kind           (rsp_if.kind),
   .rsp_status         (rsp_if.status),
   .rsp_exception_code (rsp_if.exception_code),
   .rsp_last           (rsp_if.last)
);

`default_nettype wire
